### rtl/ilis_pkg.sv
// Shared constants, types and helper functions for the indexed list block.
package ilis_pkg;

   localparam int DEPTH     = 64;
   localparam int POS_W     = $clog2(DEPTH);
   localparam int COUNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W    = 32;
   localparam int MODE_W    = 3;
   localparam int STATUS_W  = 2;

   localparam int TREE_LVLS = $clog2(DEPTH);
   localparam int LEAF_N    = 1 << TREE_LVLS;
   localparam int TREE_LAT  = (TREE_LVLS + 2) / 3;
   localparam int TLAT_W    = $clog2(TREE_LAT + 1);

   localparam int REQ_BITS    = MODE_W + POS_W + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = STATUS_W + POS_W + DATA_W + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic               search;
      logic [POS_W-1:0]   pos;
      logic [DATA_W-1:0]  value;
      logic [COUNT_W-1:0] count;
   } cell_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [POS_W-1:0]  idx;
      logic [DATA_W-1:0] data;
   } node_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      logic [MODE_W-1:0]        mode;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]       length;
      logic signed [DATA_W-1:0] read_value;
      logic [POS_W-1:0]         found_position;
      logic [STATUS_W-1:0]      status;
   } result_type;

   // The lower index wins when both halves report a hit.
   function automatic node_type node_merge(input node_type lo, input node_type hi);
      node_merge = lo.hit ? lo : hi;
   endfunction

endpackage

### rtl/ilis_cell.sv
// One list cell: holds one entry, shifts with its neighbors and reports a lookup hit.
module ilis_cell (
   input  logic                          clock,
   input  logic [ilis_pkg::POS_W-1:0]    cell_idx,
   input  ilis_pkg::cell_ctl_type        ctl,
   input  logic [ilis_pkg::DATA_W-1:0]   left_value,
   input  logic [ilis_pkg::DATA_W-1:0]   right_value,
   output logic [ilis_pkg::DATA_W-1:0]   value,
   output ilis_pkg::node_type            leaf
);
   import ilis_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              in_range;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (cell_idx > ctl.pos) begin
               value_in = left_value;
            end else if (cell_idx == ctl.pos) begin
               value_in = ctl.value;
            end
         end
         CELL_DELETE: begin
            if (cell_idx >= ctl.pos) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign in_range  = COUNT_W'(cell_idx) < ctl.count;
   assign value     = value_ff;
   assign leaf.hit  = in_range && (ctl.search ? (value_ff == ctl.value)
                                              : (cell_idx == ctl.pos));
   assign leaf.idx  = cell_idx;
   assign leaf.data = value_ff;

endmodule

### rtl/ilis_tree.sv
// Registered reduction tree that picks the lowest-index cell reporting a hit.
module ilis_tree (
   input  logic                clock,
   input  ilis_pkg::node_type  leaves [ilis_pkg::LEAF_N],
   output ilis_pkg::node_type  root
);
   import ilis_pkg::*;

   node_type view   [1:2*LEAF_N-1];
   node_type comb   [1:LEAF_N-1];

   for (genvar i = 1; i < 2 * LEAF_N; i++) begin : g_node
      if (i >= LEAF_N) begin : g_leaf
         assign view[i] = leaves[i-LEAF_N];
      end else begin : g_inner
         localparam int LVL = TREE_LVLS - ($clog2(i + 1) - 1);
         assign comb[i] = node_merge(view[2*i], view[2*i+1]);
         if ((LVL % 3 == 0) || (LVL == TREE_LVLS)) begin : g_reg
            node_type node_ff;
            always_ff @(posedge clock) begin
               node_ff <= comb[i];
            end
            assign view[i] = node_ff;
         end else begin : g_pass
            assign view[i] = comb[i];
         end
      end
   end

   assign root = view[1];

endmodule

### rtl/indexed_list_insert_delete_search.sv
// Top level of the indexed list: request control, cell chain, lookup tree and response register.
// The list lives in a chain of DEPTH cells; insert and delete shift every cell from the given
// position upward at once. A clear, insert, delete or unused mode passes through accept,
// execute and reply before the next request is taken. Search and read also go through the
// registered hit tree over all cells, counted down in the tree state between execute and reply.
// The response sits in an output register, so the next request is taken while an earlier
// transaction still waits on rsp_tready. Every request gives exactly one response transaction,
// and a rejected request leaves the list unchanged.
module indexed_list_insert_delete_search (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0 up: mode, position, value, zero fill.
   input  logic [ilis_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0 up: status, found_position, read_value, length, zero fill.
   output logic [ilis_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import ilis_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_TREE  = 4'b0100,
      S_REPLY = 4'b1000
   } ctrl_state_type;

   ctrl_state_type     state_ff, state_in;
   req_type            req_ff, req_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TLAT_W-1:0]  tree_cnt_ff, tree_cnt_in;
   result_type         result_ff, result_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   cell_ctl_type       cell_ctl;
   cell_op_type        cell_op;
   logic [DATA_W-1:0]  cell_value [DEPTH];
   node_type           leaves [LEAF_N];
   node_type           root;
   logic [COUNT_W-1:0] pos_ext;
   logic               req_fire;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_in     = req_fire ? req_type'(req_tdata[REQ_BITS-1:0]) : req_ff;
   assign pos_ext    = COUNT_W'(req_ff.position);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      tree_cnt_in  = tree_cnt_ff;
      result_in    = result_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cell_op      = CELL_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            result_in = '0;
            state_in  = S_REPLY;
            unique case (req_ff.mode) inside
               MODE_CLEAR: begin
                  count_in = '0;
               end
               MODE_INSERT: begin
                  if (pos_ext > count_ff) begin
                     result_in.status = STAT_RANGE;
                  end else if (count_ff == COUNT_W'(DEPTH)) begin
                     result_in.status = STAT_FULL;
                  end else begin
                     cell_op  = CELL_INSERT;
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               MODE_DELETE: begin
                  if (pos_ext >= count_ff) begin
                     result_in.status = STAT_RANGE;
                  end else begin
                     cell_op  = CELL_DELETE;
                     count_in = count_ff - COUNT_W'(1);
                  end
               end
               MODE_SEARCH, MODE_READ: begin
                  state_in    = S_TREE;
                  tree_cnt_in = TLAT_W'(TREE_LAT - 1);
               end
               default: begin
                  result_in.status = STAT_OK;
               end
            endcase
            result_in.length = count_in;
         end
         S_TREE: begin
            if (tree_cnt_ff == '0) begin
               state_in         = S_REPLY;
               result_in        = '0;
               result_in.length = count_ff;
               if (root.hit) begin
                  result_in.status = STAT_OK;
                  if (req_ff.mode == MODE_SEARCH) begin
                     result_in.found_position = root.idx;
                  end else begin
                     result_in.read_value = root.data;
                  end
               end else begin
                  result_in.status = (req_ff.mode == MODE_SEARCH) ? STAT_NOTFOUND
                                                                  : STAT_RANGE;
               end
            end else begin
               tree_cnt_in = tree_cnt_ff - TLAT_W'(1);
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = result_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tree_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         tree_cnt_ff  <= tree_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      result_ff <= result_in;
      rsp_ff    <= rsp_in;
   end

   assign cell_ctl.op     = cell_op;
   assign cell_ctl.search = (req_ff.mode == MODE_SEARCH);
   assign cell_ctl.pos    = req_ff.position;
   assign cell_ctl.value  = req_ff.value;
   assign cell_ctl.count  = count_ff;

   for (genvar k = 0; k < LEAF_N; k++) begin : g_cell
      if (k < DEPTH) begin : g_live
         logic [DATA_W-1:0] left_value;
         logic [DATA_W-1:0] right_value;
         if (k == 0) begin : g_first
            assign left_value = '0;
         end else begin : g_mid_l
            assign left_value = cell_value[k-1];
         end
         if (k == DEPTH - 1) begin : g_last
            assign right_value = '0;
         end else begin : g_mid_r
            assign right_value = cell_value[k+1];
         end
         ilis_cell u_cell (
            .clock       (clock),
            .cell_idx    (POS_W'(k)),
            .ctl         (cell_ctl),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[k]),
            .leaf        (leaves[k])
         );
      end else begin : g_pad
         assign leaves[k] = '0;
      end
   end

   ilis_tree u_tree (
      .clock  (clock),
      .leaves (leaves),
      .root   (root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("Entry count exceeds the list depth.");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && req_ff.mode == MODE_INSERT && pos_ext <= count_ff &&
       count_ff != COUNT_W'(DEPTH)) |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("Accepted insert did not grow the list by one entry.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.status == STAT_NOTFOUND) |->
      (rsp_ff.found_position == '0 && rsp_ff.read_value == '0))
      else $error("Search miss reported a nonzero position or value.");

   a_len_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && (!rsp_valid_ff || rsp_tready)) |=>
      (rsp_ff.length == count_ff))
      else $error("Reported length differs from the entry count.");

endmodule

### bench/tb.sv
// Self-checking testbench for the indexed list block: stream traffic checked against a list model.
module tb;
   import ilis_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_OPS  = 1650;

   typedef struct packed {
      logic    wait_idle;
      req_type req;
   } list_op_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   list_op_type              op_queue[$];
   result_type               expected_replies[$];
   logic signed [DATA_W-1:0] list_vals[DEPTH];
   int                       list_len = 0;
   logic [DATA_W-1:0]        value_pool[8];
   int                       gen_len = 0;

   list_op_type cur_op = '0;
   bit       op_offered = 1'b0;
   bit       op_taken = 1'b0;
   int       send_gap = 0;
   int       ops_sent = 0;
   int       replies_seen = 0;
   int       stall_left = 0;
   bit       long_hold_done = 1'b0;
   int       mismatch_count = 0;
   int       cycle_count = 0;

   indexed_list_insert_delete_search DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Every third window of 128 transactions runs without any idle cycles.
   function automatic int idle_length(input int seq);
      int r;
      if ((seq / 128) % 3 == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic result_type apply_list_op(input req_type op);
      result_type res;
      int         k;
      res = '0;
      case (op.mode)
         MODE_CLEAR: list_len = 0;
         MODE_INSERT: begin
            if (op.position > list_len) begin
               res.status = STAT_RANGE;
            end else if (list_len >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               for (k = list_len; k > op.position; k--) list_vals[k] = list_vals[k - 1];
               list_vals[op.position] = op.value;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (op.position >= list_len) begin
               res.status = STAT_RANGE;
            end else begin
               for (k = op.position + 1; k < list_len; k++) list_vals[k - 1] = list_vals[k];
               list_len--;
            end
         end
         MODE_SEARCH: begin
            res.status = STAT_NOTFOUND;
            for (k = 0; k < list_len; k++) begin
               if (list_vals[k] == op.value) begin
                  res.status = STAT_OK;
                  res.found_position = POS_W'(k);
                  break;
               end
            end
         end
         MODE_READ: begin
            if (op.position >= list_len) res.status = STAT_RANGE;
            else res.read_value = list_vals[op.position];
         end
         default: ;
      endcase
      res.length = COUNT_W'(list_len);
      return res;
   endfunction

   // The generator keeps its own entry count so that most positions are in range.
   task automatic add_op(input logic [MODE_W-1:0] mode, input int pos,
                         input logic [DATA_W-1:0] value, input logic wait_idle);
      list_op_type item;
      item.wait_idle    = wait_idle;
      item.req.mode     = mode;
      item.req.position = POS_W'(pos);
      item.req.value    = value;
      op_queue.push_back(item);
      case (mode)
         MODE_CLEAR:  gen_len = 0;
         MODE_INSERT: if (pos <= gen_len && gen_len < DEPTH) gen_len++;
         MODE_DELETE: if (pos < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   // Phases that grow, mix and shrink the list so that it is often filled and emptied.
   task automatic add_random_ops();
      int                n;
      int                phase;
      int                phase_left;
      int                p;
      int                ins_w;
      int                del_w;
      int                srch_w;
      int                pos;
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] value;
      phase      = 3;
      phase_left = 0;
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (phase_left == 0) begin
            phase      = (phase + 1) % 4;
            phase_left = (phase == 0) ? $urandom_range(100, 160) : $urandom_range(60, 160);
         end
         phase_left--;
         case (phase)
            0: begin
               ins_w = 80; del_w = 5; srch_w = 8;
            end
            2: begin
               ins_w = 15; del_w = 55; srch_w = 15;
            end
            default: begin
               ins_w = 30; del_w = 25; srch_w = 25;
            end
         endcase
         p = $urandom_range(0, 999);
         if (p < 6) begin
            mode = MODE_CLEAR;
         end else if (p < 16) begin
            mode = MODE_W'($urandom_range(5, 7));
         end else begin
            p = $urandom_range(0, 99);
            if (p < ins_w) mode = MODE_INSERT;
            else if (p < ins_w + del_w) mode = MODE_DELETE;
            else if (p < ins_w + del_w + srch_w) mode = MODE_SEARCH;
            else mode = MODE_READ;
         end
         if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, DEPTH - 1);
         else if (mode == MODE_INSERT)
            pos = $urandom_range(0, (gen_len < DEPTH) ? gen_len : DEPTH - 1);
         else if (gen_len > 0) pos = $urandom_range(0, gen_len - 1);
         else pos = $urandom_range(0, DEPTH - 1);
         if ($urandom_range(0, 9) < 6) value = value_pool[$urandom_range(0, 7)];
         else value = $urandom;
         add_op(mode, pos, value, n == 700 || n == 1300);
      end
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (op_taken) begin
            op_taken   = 1'b0;
            op_offered = 1'b0;
         end
         if (!op_offered) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (op_queue.size() > 0 &&
                         !(op_queue[0].wait_idle && expected_replies.size() > 0)) begin
               cur_op     = op_queue.pop_front();
               op_offered = 1'b1;
               ops_sent++;
               send_gap   = idle_length(ops_sent);
            end
         end
         req_tvalid <= op_offered;
         req_tdata  <= REQ_TDATA_W'(cur_op.req);
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && replies_seen >= 500) begin
            long_hold_done = 1'b1;
            stall_left     = 299;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = idle_length(replies_seen + 64);
         end
      end
   end

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            replies_seen++;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Reply %0d arrived with no request outstanding.", replies_seen);
            end else begin
               want = expected_replies.pop_front();
               if (got.status !== want.status || got.found_position !== want.found_position ||
                   got.read_value !== want.read_value || got.length !== want.length) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("Reply %0d: expected status %0d index %0d value %0d length %0d,",
                            replies_seen, want.status, want.found_position, want.read_value,
                            want.length);
                     $display(" got status %0d index %0d value %0d length %0d.",
                              got.status, got.found_position, got.read_value, got.length);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(apply_list_op(cur_op.req));
            op_taken = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      add_op(MODE_READ,   0,  32'd0,        1'b0);
      add_op(MODE_DELETE, 0,  32'd0,        1'b0);
      add_op(MODE_SEARCH, 0,  32'd0,        1'b0);
      add_op(MODE_INSERT, 1,  32'd5,        1'b0);
      add_op(MODE_INSERT, 0,  32'h7fff_ffff, 1'b0);
      add_op(MODE_INSERT, 0,  32'h8000_0000, 1'b0);
      add_op(MODE_INSERT, 2,  32'd0,        1'b0);
      add_op(MODE_INSERT, 1,  32'hffff_ffff, 1'b0);
      add_op(MODE_INSERT, 4,  32'hffff_ffff, 1'b0);
      add_op(MODE_SEARCH, 0,  32'hffff_ffff, 1'b0);
      add_op(MODE_SEARCH, 63, 32'h8000_0000, 1'b0);
      add_op(MODE_SEARCH, 0,  32'd12345,    1'b0);
      add_op(MODE_READ,   0,  32'd0,        1'b0);
      add_op(MODE_READ,   4,  32'd0,        1'b0);
      add_op(MODE_READ,   5,  32'd0,        1'b0);
      add_op(MODE_INSERT, 63, 32'd7,        1'b0);
      add_op(MODE_DELETE, 1,  32'd0,        1'b0);
      add_op(MODE_DELETE, 3,  32'd0,        1'b0);
      add_op(MODE_DELETE, 3,  32'd0,        1'b0);
      add_op(MODE_READ,   1,  32'd0,        1'b0);
      add_op(3'd5,        63, 32'hffff_ffff, 1'b0);
      add_op(3'd6,        21, 32'h5555_5555, 1'b0);
      add_op(3'd7,        42, 32'haaaa_aaaa, 1'b0);
      add_op(MODE_CLEAR,  0,  32'd0,        1'b0);
      add_op(MODE_SEARCH, 0,  32'h7fff_ffff, 1'b0);
      add_random_ops();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (op_queue.size() > 0 || op_offered || expected_replies.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/ilis_pkg.sv
rtl/ilis_cell.sv
rtl/ilis_tree.sv
rtl/indexed_list_insert_delete_search.sv
bench/tb.sv
